/* rtl/core/psas_pkg.sv */
// Package for the parity-split append store: field widths, command and
// result codes, and the command/status structs between controller and datapath.
// No dependencies.
package psas_pkg;

  localparam int unsigned DEFAULT_BANK_DEPTH = 64;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CAP_W   = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED  = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_MATCH     = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_LISTED    = 3'd4,
    KIND_EMPTY     = 3'd5
  } kind_e;

  typedef struct packed {
    logic  load;      // capture the accepted item
    logic  write;     // append the captured word to its bank
    logic  rd_en;     // read the entry at the scan index
    logic  idx_inc;   // advance the scan index
    logic  pend_set;  // remember the scan index as the pending match
    logic  emit;      // load the output register
    kind_e kind;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;     // selected bank is empty
    logic idx_last;   // scan index is at the last filled entry
    logic match;      // read word equals the search word
    logic ins_ok;     // selected bank has room below the capacity
    logic pend_valid; // a match is held back until its last flag is known
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

/* rtl/core/psas_if.sv */
// Valid/ready channel interfaces for the command items and the result items.
// Depends on psas_pkg for field widths.
interface psas_in_if;
  logic                              valid;
  logic                              ready;
  logic [psas_pkg::CMD_W-1:0]        cmd;
  logic signed [psas_pkg::WORD_W-1:0] value;
  logic                              bank_select;

  modport source (output valid, output cmd, output value, output bank_select, input ready);
  modport sink   (input valid, input cmd, input value, input bank_select, output ready);
endinterface

interface psas_out_if;
  logic                              valid;
  logic                              ready;
  logic [psas_pkg::KIND_W-1:0]       kind;
  logic [psas_pkg::POS_W-1:0]        position;
  logic signed [psas_pkg::WORD_W-1:0] item_value;
  logic                              last;

  modport source (output valid, output kind, output position, output item_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input position, input item_value,
                  input last, output ready);
endinterface

/* rtl/core/psas_ctrl.sv */
// Controller state machine: dispatches each item and sequences the bank scan.
// Depends on psas_pkg; drives psas_dp through dp_cmd_t and reads dp_status_t.
module psas_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [psas_pkg::CMD_W-1:0] in_cmd_i,
  output logic                  in_ready_o,
  input  psas_pkg::dp_status_t  status_i,
  output psas_pkg::dp_cmd_t     cmd_o
);
  import psas_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_START,
    ST_READ,
    ST_CHECK,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   dump_q, dump_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    cmd_o.kind = KIND_INSERTED;
    state_d = state_q;
    dump_d  = dump_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (cmd_e'(in_cmd_i))
            CMD_INSERT: state_d = ST_INSERT;
            CMD_SEARCH: begin
              dump_d  = 1'b0;
              state_d = ST_START;
            end
            CMD_DUMP: begin
              dump_d  = 1'b1;
              state_d = ST_START;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INSERT: begin
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = status_i.ins_ok ? KIND_INSERTED : KIND_FULL;
          cmd_o.last  = 1'b1;
          cmd_o.write = status_i.ins_ok;
          state_d     = ST_IDLE;
        end
      end
      ST_START: begin
        state_d = status_i.n_zero ? ST_FINAL : ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (dump_q) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_LISTED;
            cmd_o.last = status_i.idx_last;
            if (status_i.idx_last) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = ST_READ;
            end
          end
        end else if (!(status_i.match && status_i.pend_valid && !status_i.out_free)) begin
          // A new match releases the held one, which then cannot be the last.
          if (status_i.match) begin
            cmd_o.pend_set = 1'b1;
            cmd_o.emit     = status_i.pend_valid;
            cmd_o.kind     = KIND_MATCH;
          end
          if (status_i.idx_last) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      ST_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (dump_q) begin
            cmd_o.kind = KIND_EMPTY;
          end else if (status_i.pend_valid) begin
            cmd_o.kind = KIND_MATCH;
          end else begin
            cmd_o.kind = KIND_NOT_FOUND;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dump_q  <= dump_d;
    end
  end

endmodule

/* rtl/core/psas_dp.sv */
// Datapath: the two bank memories, fill counts, capacity register, scan index,
// pending match and output register. Depends on psas_pkg and psas_out_if.
module psas_dp #(
  parameter int unsigned BANK_DEPTH = psas_pkg::DEFAULT_BANK_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psas_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic [psas_pkg::CMD_W-1:0]   in_cmd_i,
  input  logic signed [psas_pkg::WORD_W-1:0] in_value_i,
  input  logic                         in_bank_select_i,
  input  psas_pkg::dp_cmd_t            cmd_i,
  output psas_pkg::dp_status_t         status_o,
  psas_out_if.source                   out_o
);
  import psas_pkg::*;

  localparam int unsigned IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(BANK_DEPTH + 1);
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(BANK_DEPTH);

  logic [WORD_W-1:0] even_mem [BANK_DEPTH];
  logic [WORD_W-1:0] odd_mem  [BANK_DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  logic [CNT_W-1:0]  even_cnt_q, odd_cnt_q, n_cnt;
  logic [CAP_W-1:0]  cap_q, cap_eff;
  logic [WORD_W-1:0] word_q;
  logic              bank_q;
  logic [IDX_W-1:0]  idx_q, pend_q;
  logic              pend_valid_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [POS_W-1:0]  out_pos_q, pos_d;
  logic [WORD_W-1:0] out_val_q, val_d;
  logic              out_last_q;

  assign n_cnt   = bank_q ? odd_cnt_q : even_cnt_q;
  assign cap_eff = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;

  assign status_o.n_zero     = (n_cnt == '0);
  assign status_o.idx_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == n_cnt);
  assign status_o.match      = (rd_data_q == word_q);
  assign status_o.ins_ok     = (CAP_W'(n_cnt) < cap_eff);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Captured item: a dump picks its bank by the select bit, otherwise by parity.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= in_value_i;
      bank_q <= (cmd_e'(in_cmd_i) == CMD_DUMP) ? in_bank_select_i : in_value_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_cnt_q <= '0;
      odd_cnt_q  <= '0;
    end else if (cmd_i.write) begin
      if (bank_q) begin
        odd_cnt_q <= odd_cnt_q + CNT_W'(1);
      end else begin
        even_cnt_q <= even_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      if (bank_q) begin
        odd_mem[n_cnt[IDX_W-1:0]] <= word_q;
      end else begin
        even_mem[n_cnt[IDX_W-1:0]] <= word_q;
      end
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= bank_q ? odd_mem[idx_q] : even_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (cmd_i.pend_set) begin
          pend_q       <= idx_q;
          pend_valid_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    pos_d = '0;
    val_d = '0;
    unique case (cmd_i.kind)
      KIND_MATCH:  pos_d = POS_W'(pend_q);
      KIND_LISTED: begin
        pos_d = POS_W'(idx_q);
        val_d = rd_data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_pos_q  <= pos_d;
      out_val_q  <= val_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.position   = out_pos_q;
  assign out_o.item_value = out_val_q;
  assign out_o.last       = out_last_q;

endmodule

/* rtl/core/parity_split_append_search_store.sv */
// Top level of the parity-split append store: controller plus datapath.
// Depends on psas_pkg, psas_if, psas_ctrl and psas_dp.
//
// Two append-only banks of 32-bit words; even words go to one bank, odd words
// to the other. A search or dump of a bank holding n entries walks the bank
// through one memory read port, reading each entry and then comparing or
// listing it, and waits whenever the result side stalls; an empty bank is
// not read. A new item is accepted once the previous one has loaded its
// last result into the output register. Search matches are held back until
// the next match or the end of the scan so the final match can carry the
// last flag.
module parity_split_append_search_store #(
  parameter int unsigned BANK_DEPTH = psas_pkg::DEFAULT_BANK_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [psas_pkg::CAP_W-1:0] cfg_wdata_i,
  psas_in_if.sink                    in_i,
  psas_out_if.source                 out_o
);
  import psas_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  psas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  psas_dp #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_cmd_i         (in_i.cmd),
    .in_value_i       (in_i.value),
    .in_bank_select_i (in_i.bank_select),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .out_o            (out_o)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for parity_split_append_search_store: directed and random
// insert/search/dump items through the valid/ready channels, checked against a local
// model of both banks. Depends on psas_pkg, psas_if and the RTL of the block.
module tb_top;
  import psas_pkg::*;

  localparam int BANK_DEPTH   = 64;
  localparam int DRAIN_CYCLES = 160;

  typedef struct {
    cmd_e         cmd;
    logic [31:0]  value;
    logic         bank_select;
  } cmd_item_t;

  typedef struct {
    kind_e        kind;
    logic [5:0]   position;
    logic [31:0]  item_value;
    logic         last;
  } store_response_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  psas_in_if  in_ch ();
  psas_out_if out_ch ();

  parity_split_append_search_store #(.BANK_DEPTH(BANK_DEPTH)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #6 clk = ~clk;

  // Local copy of both banks, the fill levels and the capacity register.
  logic [31:0]      bank_words [2][BANK_DEPTH];
  int               fill_level [2] = '{0, 0};
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;

  cmd_item_t        commands_to_send [$];
  store_response_t  responses_due [$];
  cmd_item_t        next_cmd;
  store_response_t  oldest_due;
  int               error_count = 0;
  int unsigned      cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Idle with a chance of about 7 in a hundred, never inside a long quiet window.
  function automatic bit idle_roll();
    if ((cycle_count % 6000) >= 3000 && (cycle_count % 6000) < 5000)
      return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  function automatic void add_due_response(kind_e kind, int pos, logic [31:0] word,
                                           logic last);
    store_response_t r;
    r.kind       = kind;
    r.position   = pos[5:0];
    r.item_value = word;
    r.last       = last;
    responses_due.push_back(r);
  endfunction

  task automatic predict_store_response(input cmd_e op, input logic [31:0] word,
                                        input logic sel);
    int side;
    int limit;
    int hits;
    int seen;
    int i;
    side  = (op == CMD_DUMP) ? int'(sel) : int'(word[0]);
    limit = (capacity_setting > BANK_DEPTH) ? BANK_DEPTH : int'(capacity_setting);
    hits  = 0;
    seen  = 0;
    unique case (op)
      CMD_INSERT: begin
        if (fill_level[side] < limit) begin
          bank_words[side][fill_level[side]] = word;
          fill_level[side]++;
          add_due_response(KIND_INSERTED, 0, '0, 1'b1);
        end else begin
          add_due_response(KIND_FULL, 0, '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < fill_level[side]; i++)
          if (bank_words[side][i] == word) hits++;
        if (hits == 0) begin
          add_due_response(KIND_NOT_FOUND, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < fill_level[side]; i++) begin
            if (bank_words[side][i] == word) begin
              seen++;
              add_due_response(KIND_MATCH, i, '0, seen == hits);
            end
          end
        end
      end
      CMD_DUMP: begin
        if (fill_level[side] == 0) begin
          add_due_response(KIND_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < fill_level[side]; i++)
            add_due_response(KIND_LISTED, i, bank_words[side][i],
                             i == fill_level[side] - 1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Driver: the model is updated at the edge where the DUT takes the item.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.cmd         <= CMD_INSERT;
      in_ch.value       <= '0;
      in_ch.bank_select <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_store_response(cmd_e'(in_ch.cmd), in_ch.value, in_ch.bank_select);
      if (!in_ch.valid || in_ch.ready) begin
        if (commands_to_send.size() != 0 && !idle_roll()) begin
          next_cmd          = commands_to_send.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.cmd         <= next_cmd.cmd;
          in_ch.value       <= next_cmd.value;
          in_ch.bank_select <= next_cmd.bank_select;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result item is matched against the oldest one due.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (responses_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d position %0d %s",
                   $time, out_ch.kind, out_ch.position,
                   $sformatf("value %h last %0d", out_ch.item_value, out_ch.last));
          error_count++;
        end else begin
          oldest_due = responses_due.pop_front();
          check_field("kind", 32'(oldest_due.kind), 32'(out_ch.kind));
          check_field("position", 32'(oldest_due.position), 32'(out_ch.position));
          check_field("item_value", oldest_due.item_value, out_ch.item_value);
          check_field("last", 32'(oldest_due.last), 32'(out_ch.last));
        end
      end
      out_ch.ready <= !idle_roll();
    end
  end

  task automatic queue_item(input cmd_e op, input logic [31:0] word, input logic sel);
    cmd_item_t it;
    it.cmd         = op;
    it.value       = word;
    it.bank_select = sel;
    commands_to_send.push_back(it);
  endtask

  // Mix of full-range words, a small pool, the extremes and words already stored,
  // so that searches hit often.
  function automatic logic [31:0] rand_word();
    int pick;
    int side;
    pick = $urandom_range(0, 3);
    side = $urandom_range(0, 1);
    unique case (pick)
      0: return $urandom;
      1: return 32'($urandom_range(0, 9)) - 32'd5;
      2: begin
        unique case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: begin
        if (fill_level[side] > 0)
          return bank_words[side][$urandom_range(0, fill_level[side] - 1)];
        return $urandom;
      end
    endcase
  endfunction

  task automatic queue_random(input int count, input int insert_pct, input int search_pct);
    int n;
    int r;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct)
        queue_item(CMD_INSERT, rand_word(), 1'($urandom_range(0, 1)));
      else if (r < insert_pct + search_pct)
        queue_item(CMD_SEARCH, rand_word(), 1'($urandom_range(0, 1)));
      else if (r < 96)
        queue_item(CMD_DUMP, rand_word(), 1'($urandom_range(0, 1)));
      else
        queue_item(CMD_NONE, rand_word(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic fill_bank(input int side, input int target);
    int n;
    for (n = fill_level[side]; n < target; n++)
      queue_item(CMD_INSERT, side ? (rand_word() | 32'd1) : (rand_word() & ~32'd1),
                 1'($urandom_range(0, 1)));
  endtask

  // Waits until every item is sent and answered, then lets an ignored item finish.
  task automatic wait_drained();
    do @(negedge clk);
    while (commands_to_send.size() != 0 || in_ch.valid || responses_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we           <= 1'b1;
    cfg_wdata        <= cap;
    capacity_setting = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty banks, extremes of the word, duplicates and ignored command 3.
    queue_item(CMD_DUMP, 32'h0, 1'b0);
    queue_item(CMD_DUMP, 32'hffff_ffff, 1'b1);
    queue_item(CMD_SEARCH, 32'h0, 1'b1);
    queue_item(CMD_SEARCH, 32'hffff_ffff, 1'b0);
    queue_item(CMD_INSERT, 32'h0, 1'b1);
    queue_item(CMD_INSERT, 32'h8000_0000, 1'b0);
    queue_item(CMD_INSERT, 32'h7fff_ffff, 1'b0);
    queue_item(CMD_INSERT, 32'hffff_ffff, 1'b1);
    queue_item(CMD_INSERT, 32'h0, 1'b0);
    queue_item(CMD_INSERT, 32'h5555_5555, 1'b1);
    queue_item(CMD_INSERT, 32'haaaa_aaaa, 1'b0);
    queue_item(CMD_SEARCH, 32'h0, 1'b0);
    queue_item(CMD_SEARCH, 32'hffff_ffff, 1'b1);
    queue_item(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    queue_item(CMD_SEARCH, 32'h1234_5678, 1'b1);
    queue_item(CMD_DUMP, 32'h0, 1'b0);
    queue_item(CMD_DUMP, 32'h0, 1'b1);
    queue_item(CMD_NONE, 32'hffff_ffff, 1'b1);
    queue_item(CMD_NONE, 32'h0, 1'b0);
    wait_drained();

    // With capacity zero every insert is refused.
    set_capacity(7'd0);
    queue_item(CMD_INSERT, 32'h8, 1'b0);
    queue_item(CMD_INSERT, 32'h9, 1'b1);
    queue_item(CMD_SEARCH, 32'h8, 1'b0);
    queue_item(CMD_DUMP, 32'h0, 1'b0);
    wait_drained();

    // Capacity below the fill levels: refused, but stored entries remain visible.
    set_capacity(7'd1);
    queue_item(CMD_INSERT, 32'h2, 1'b1);
    queue_item(CMD_INSERT, 32'h3, 1'b0);
    queue_item(CMD_SEARCH, 32'h8000_0000, 1'b1);
    queue_item(CMD_DUMP, 32'h0, 1'b1);
    wait_drained();

    set_capacity(7'd20);
    queue_random(60, 50, 30);
    wait_drained();

    // Largest register value saturates to the bank depth.
    set_capacity(7'd127);
    queue_random(40, 60, 25);
    wait_drained();
    fill_bank(1, BANK_DEPTH);
    fill_bank(0, BANK_DEPTH - 1);
    queue_item(CMD_INSERT, 32'hffff_fffd, 1'b0);
    queue_item(CMD_DUMP, 32'h0, 1'b1);
    wait_drained();

    set_capacity(7'd64);
    queue_item(CMD_INSERT, 32'hffff_fffe, 1'b1);
    queue_item(CMD_INSERT, 32'h0000_0004, 1'b0);
    queue_item(CMD_DUMP, 32'h0, 1'b0);
    queue_random(40, 30, 50);
    wait_drained();

    set_capacity(7'd65);
    queue_random(15, 40, 40);
    wait_drained();

    set_capacity(7'd10);
    queue_random(25, 40, 40);
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
rtl/core/psas_pkg.sv
rtl/core/psas_if.sv
rtl/core/psas_ctrl.sv
rtl/core/psas_dp.sv
rtl/core/parity_split_append_search_store.sv
verif/tb_top.sv
